// ----- rtl/core/vsp_pkg.sv -----
// Shared types, phase codes and character constants of the version string parser.
`default_nettype none

package vsp_pkg;

   // Parse phases
   localparam logic [3:0] PH_LEAD   = 4'd0;
   localparam logic [3:0] PH_MAJOR  = 4'd1;
   localparam logic [3:0] PH_MINOR  = 4'd2;
   localparam logic [3:0] PH_PATCH  = 4'd3;
   localparam logic [3:0] PH_PRE    = 4'd4;
   localparam logic [3:0] PH_BSTART = 4'd5;
   localparam logic [3:0] PH_BUILD  = 4'd6;
   localparam logic [3:0] PH_TRAIL  = 4'd7;
   localparam logic [3:0] PH_ERR    = 4'd8;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_V_UP  = 8'h56;
   localparam logic [7:0] CH_V_LOW = 8'h76;

   localparam logic [7:0] TAG_MAX  = 8'hFF;

   // Running parse state
   typedef struct packed {
      logic [3:0]  phase;
      logic [31:0] acc;
      logic        digit_seen;
      logic        leading_zero;
      logic [31:0] major_held;
      logic [31:0] minor_held;
      logic [7:0]  tag_count;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase:        PH_LEAD,
      acc:          32'd0,
      digit_seen:   1'b0,
      leading_zero: 1'b0,
      major_held:   32'd0,
      minor_held:   32'd0,
      tag_count:    8'd0
   };

   // One result item
   typedef struct packed {
      logic [7:0]  prerelease_length;
      logic        has_prerelease;
      logic [31:0] patch_number;
      logic [31:0] minor_number;
      logic [31:0] major_number;
      logic        valid_res;
   } result_type;

   localparam int RSP_DATA_W = 112;

endpackage

`default_nettype wire

// ----- rtl/core/vsp_step.sv -----
// Combinational next-state and result logic for one character of the version string.
`default_nettype none

module vsp_step
   import vsp_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      text_byte,
   output parse_state_type nxt_state,
   output logic            emit,
   output result_type      result
);

   logic        is_end;
   logic        is_digit;
   logic        is_ws;
   logic        ok;
   logic [31:0] base_acc;
   logic        base_seen;
   logic        base_lz;
   logic [35:0] prod;
   logic        digit_ok;
   logic        new_lz;

   assign is_end   = (text_byte == CH_NUL);
   assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
   assign is_ws    = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                     (text_byte == CH_LF) || (text_byte == CH_CR);

   // Digit accumulate: a fresh number starts from zero in the leading phase
   assign base_acc  = (cur_state.phase == PH_LEAD) ? 32'd0 : cur_state.acc;
   assign base_seen = (cur_state.phase == PH_LEAD) ? 1'b0  : cur_state.digit_seen;
   assign base_lz   = (cur_state.phase == PH_LEAD) ? 1'b0  : cur_state.leading_zero;

   // acc * 10 + digit, as acc*8 + acc*2
   assign prod = ({4'd0, base_acc} << 3) + ({4'd0, base_acc} << 1) +
                 {32'd0, text_byte[3:0] - CH_ZERO[3:0]};
   assign digit_ok = !(base_seen && base_lz) && (prod[35:32] == 4'd0);
   assign new_lz   = base_lz | (!base_seen && (text_byte == CH_ZERO));

   // Phase transitions
   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      ok        = 1'b0;
      case (cur_state.phase)
         PH_LEAD: begin
            if (is_end) begin
               emit = 1'b1;
            end else if ((text_byte == CH_SPACE) || (text_byte == CH_TAB)) begin
               nxt_state = cur_state;
            end else begin
               nxt_state.phase        = PH_MAJOR;
               nxt_state.acc          = 32'd0;
               nxt_state.digit_seen   = 1'b0;
               nxt_state.leading_zero = 1'b0;
               if ((text_byte == CH_V_LOW) || (text_byte == CH_V_UP)) begin
                  nxt_state.phase = PH_MAJOR;
               end else if (is_digit && digit_ok) begin
                  nxt_state.acc          = prod[31:0];
                  nxt_state.digit_seen   = 1'b1;
                  nxt_state.leading_zero = new_lz;
               end else begin
                  nxt_state.phase = PH_ERR;
               end
            end
         end
         PH_MAJOR, PH_MINOR: begin
            if (is_end) begin
               emit = 1'b1;
            end else if (is_digit) begin
               if (digit_ok) begin
                  nxt_state.acc          = prod[31:0];
                  nxt_state.digit_seen   = 1'b1;
                  nxt_state.leading_zero = new_lz;
               end else begin
                  nxt_state.phase = PH_ERR;
               end
            end else if (!cur_state.digit_seen || (text_byte != CH_DOT)) begin
               nxt_state.phase = PH_ERR;
            end else begin
               if (cur_state.phase == PH_MAJOR) begin
                  nxt_state.major_held = cur_state.acc;
                  nxt_state.phase      = PH_MINOR;
               end else begin
                  nxt_state.minor_held = cur_state.acc;
                  nxt_state.phase      = PH_PATCH;
               end
               nxt_state.acc          = 32'd0;
               nxt_state.digit_seen   = 1'b0;
               nxt_state.leading_zero = 1'b0;
            end
         end
         PH_PATCH: begin
            if (is_digit) begin
               if (digit_ok) begin
                  nxt_state.acc          = prod[31:0];
                  nxt_state.digit_seen   = 1'b1;
                  nxt_state.leading_zero = new_lz;
               end else begin
                  nxt_state.phase = PH_ERR;
               end
            end else if (!cur_state.digit_seen) begin
               if (is_end) begin
                  emit = 1'b1;
               end else begin
                  nxt_state.phase = PH_ERR;
               end
            end else if (is_end) begin
               emit = 1'b1;
               ok   = 1'b1;
            end else if (text_byte == CH_DASH) begin
               nxt_state.phase     = PH_PRE;
               nxt_state.tag_count = 8'd0;
            end else if (text_byte == CH_PLUS) begin
               nxt_state.phase = PH_BSTART;
            end else if (is_ws) begin
               nxt_state.phase = PH_TRAIL;
            end else begin
               nxt_state.phase = PH_ERR;
            end
         end
         PH_PRE: begin
            if (is_end || (text_byte == CH_PLUS) || (text_byte == CH_SPACE)) begin
               if (cur_state.tag_count == 8'd0) begin
                  if (is_end) begin
                     emit = 1'b1;
                  end else begin
                     nxt_state.phase = PH_ERR;
                  end
               end else if (is_end) begin
                  emit = 1'b1;
                  ok   = 1'b1;
               end else begin
                  nxt_state.phase = (text_byte == CH_PLUS) ? PH_BSTART : PH_TRAIL;
               end
            end else if (cur_state.tag_count != TAG_MAX) begin
               nxt_state.tag_count = cur_state.tag_count + 8'd1;
            end
         end
         PH_BSTART: begin
            if (is_end) begin
               emit = 1'b1;
            end else begin
               nxt_state.phase = (text_byte == CH_SPACE) ? PH_TRAIL : PH_BUILD;
            end
         end
         PH_BUILD: begin
            if (is_end) begin
               emit = 1'b1;
               ok   = 1'b1;
            end else if (text_byte == CH_SPACE) begin
               nxt_state.phase = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            if (is_end) begin
               emit = 1'b1;
               ok   = 1'b1;
            end else if (!is_ws) begin
               nxt_state.phase = PH_ERR;
            end
         end
         default: begin
            // error phase and unused codes: absorb until the terminator
            if (is_end) begin
               emit = 1'b1;
            end else begin
               nxt_state.phase = PH_ERR;
            end
         end
      endcase
      // a result always starts the next string from scratch
      if (emit) begin
         nxt_state = STATE_CLEAR;
      end
   end

   // Result fields, all zero on a malformed string
   always_comb begin
      result.valid_res         = ok;
      result.major_number      = ok ? cur_state.major_held : 32'd0;
      result.minor_number      = ok ? cur_state.minor_held : 32'd0;
      result.patch_number      = ok ? cur_state.acc : 32'd0;
      result.has_prerelease    = ok && (cur_state.tag_count != 8'd0);
      result.prerelease_length = ok ? cur_state.tag_count : 8'd0;
   end

endmodule

`default_nettype wire

// ----- rtl/core/version_string_parser.sv -----
// Top level of the version string parser: input register, parse state and result register.
`default_nettype none

// The parser takes one character item per clock and returns one result item for each
// zero byte. A character is first caught in an input register; from there the phase logic
// (including the times-ten accumulate of the current number) updates the parse state
// and, on a zero byte, loads the result register. Sustained rate is one character per
// cycle while no zero byte waits, set by that state update; rsp_tvalid is driven by the
// result register, so it rises once a zero byte's result is loaded there. Characters
// keep flowing while a result waits; only a further zero byte waits for the result
// register to empty.
// There are no configuration registers.
module version_string_parser
   import vsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // fields from bit 0: text_byte[7:0]
   input  logic [7:0]            req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // fields from bit 0: valid_res[0], major_number[32:1], minor_number[64:33],
   // patch_number[96:65], has_prerelease[97], prerelease_length[105:98], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   result_type      out_res_ff;
   parse_state_type step_state;
   logic            step_emit;
   result_type      step_res;
   logic            out_free;
   logic            advance;
   logic            req_take;

   vsp_step u_step (
      .cur_state (state_ff),
      .text_byte (in_byte_ff),
      .nxt_state (step_state),
      .emit      (step_emit),
      .result    (step_res)
   );

   // Handshake: a terminator only moves on when the result register can take it
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!step_emit || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign state_in     = advance ? step_state : state_ff;
   assign out_valid_in = (advance && step_emit) || (out_valid_ff && !rsp_tready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && step_emit) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, out_res_ff};

`ifndef ASSERT_OFF
   // a new result only follows a terminator that moved through the step logic
   a_result_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && (in_byte_ff == CH_NUL)))
      else $error("result without a terminator");

   // a terminator never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit) |-> out_free)
      else $error("result register overwritten");

   // after a result the parse restarts in the leading phase
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit) |=> (state_ff.phase == PH_LEAD) && (state_ff.tag_count == 8'd0))
      else $error("parse state not cleared after result");

   // a malformed string reports all-zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_res_ff.valid_res) |->
         (out_res_ff.major_number == 32'd0) && (out_res_ff.minor_number == 32'd0) &&
         (out_res_ff.patch_number == 32'd0) && (out_res_ff.prerelease_length == 8'd0))
      else $error("invalid result with non-zero fields");

   // prerelease flag agrees with the length
   a_pre_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         (out_res_ff.has_prerelease == (out_res_ff.prerelease_length != 8'd0)))
      else $error("prerelease flag and length disagree");
`endif

endmodule

`default_nettype wire
